@@ rtl/core/gdr_pkg.sv @@
// Shared types and constants for the gamepad deadzone and rescale core.
package gdr_pkg;

  localparam int NUM_LANES = 6;
  localparam int NUM_AXES  = 4;

  // Configuration register indexes.
  localparam logic REG_AXIS_DEAD   = 1'b0;
  localparam logic REG_TRIG_DEAD   = 1'b1;

  localparam logic [7:0] AXIS_FULL = 8'd127;
  localparam logic [7:0] TRIG_FULL = 8'd255;

  // Reciprocals ceil(2^32 / D) for the divisors that follow from a zero deadzone.
  localparam int RECIP_W = 33;
  localparam logic [RECIP_W-1:0] AXIS_RECIP_RST = 33'd33818641;
  localparam logic [RECIP_W-1:0] TRIG_RECIP_RST = 33'd16843010;

  localparam int PROD_W = RECIP_W + 8;

  typedef struct packed {
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
    logic        [7:0] left_trig;
    logic        [7:0] right_trig;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] norm_left_x;
    logic signed [15:0] norm_left_y;
    logic signed [15:0] norm_right_x;
    logic signed [15:0] norm_right_y;
    logic        [15:0] norm_left_trig;
    logic        [15:0] norm_right_trig;
  } out_item_t;

  // Per-lane settings handed down from the configuration registers.
  typedef struct packed {
    logic               axis;
    logic [7:0]         dead;
    logic [RECIP_W-1:0] recip;
    logic               full;
  } lane_cfg_t;

endpackage

@@ rtl/core/gamepad_deadzone_rescale_core.sv @@
// Top level of the gamepad deadzone and rescale core: config, six lanes, output register.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+------------
//   input   | in_valid, in_stall, in_data                | request in
//   result  | out_valid, out_stall, out_data             | request out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_wdata | write in
//
// One request per cycle when neither output nor divider stalls, via the lane multiply
// register, then the output register. A config write recomputes that register's
// reciprocal in the shared serial divider, which holds in_stall and drops cfg_ready.
// Reset loads the reciprocals of the zero deadzones, so no divider pass follows reset.
// A stalled result does not block a new request while the lane stage is empty.
module gamepad_deadzone_rescale_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gdr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gdr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);

  logic [6:0]                  axis_dead_r;
  logic [7:0]                  trig_dead_r;
  logic [gdr_pkg::RECIP_W-1:0] axis_recip_r;
  logic [gdr_pkg::RECIP_W-1:0] trig_recip_r;
  logic                        sel_r;

  logic                        cfg_wr;
  logic                        div_start;
  logic [7:0]                  div_divisor;
  logic                        div_busy;
  logic                        div_done;
  logic [gdr_pkg::RECIP_W-1:0] div_quot;

  logic                        v1_r, v1_nxt;
  logic                        out_valid_r, out_valid_nxt;
  gdr_pkg::out_item_t          out_data_r;
  logic                        en1, en2, acc;

  gdr_pkg::lane_cfg_t          axis_cfg, trig_cfg;
  logic [7:0]                  raw_a [gdr_pkg::NUM_LANES];
  logic [15:0]                 res_a [gdr_pkg::NUM_LANES];

  assign cfg_ready   = !div_busy;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign div_start   = cfg_wr;
  assign div_divisor = (cfg_index == gdr_pkg::REG_AXIS_DEAD)
                       ? 8'(gdr_pkg::AXIS_FULL - {1'b0, cfg_wdata[6:0]})
                       : 8'(gdr_pkg::TRIG_FULL - cfg_wdata);

  gdr_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (div_divisor),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_dead_r  <= 7'd0;
      trig_dead_r  <= 8'd0;
      axis_recip_r <= gdr_pkg::AXIS_RECIP_RST;
      trig_recip_r <= gdr_pkg::TRIG_RECIP_RST;
      sel_r        <= gdr_pkg::REG_AXIS_DEAD;
    end else begin
      if (cfg_wr) begin
        sel_r <= cfg_index;
        if (cfg_index == gdr_pkg::REG_AXIS_DEAD) begin
          axis_dead_r <= cfg_wdata[6:0];
        end else begin
          trig_dead_r <= cfg_wdata;
        end
      end
      if (div_done) begin
        if (sel_r == gdr_pkg::REG_AXIS_DEAD) begin
          axis_recip_r <= div_quot;
        end else begin
          trig_recip_r <= div_quot;
        end
      end
    end
  end

  // A deadzone at full scale leaves no range: any value that clears it reads as full.
  assign axis_cfg.axis  = 1'b1;
  assign axis_cfg.dead  = {1'b0, axis_dead_r};
  assign axis_cfg.recip = axis_recip_r;
  assign axis_cfg.full  = ({1'b0, axis_dead_r} == gdr_pkg::AXIS_FULL);

  assign trig_cfg.axis  = 1'b0;
  assign trig_cfg.dead  = trig_dead_r;
  assign trig_cfg.recip = trig_recip_r;
  assign trig_cfg.full  = (trig_dead_r == gdr_pkg::TRIG_FULL);

  assign en2      = !out_valid_r || !out_stall;
  assign en1      = !v1_r || en2;
  assign in_stall = div_busy || !en1;
  assign acc      = in_valid && !in_stall;

  assign raw_a[0] = in_data.left_x;
  assign raw_a[1] = in_data.left_y;
  assign raw_a[2] = in_data.right_x;
  assign raw_a[3] = in_data.right_y;
  assign raw_a[4] = in_data.left_trig;
  assign raw_a[5] = in_data.right_trig;

  for (genvar i = 0; i < gdr_pkg::NUM_LANES; i++) begin : g_lane
    gdr_lane u_lane (
      .clk    (clk),
      .en     (en1),
      .lcfg   ((i < gdr_pkg::NUM_AXES) ? axis_cfg : trig_cfg),
      .raw    (raw_a[i]),
      .result (res_a[i])
    );
  end

  assign v1_nxt        = en1 ? acc : v1_r;
  assign out_valid_nxt = en2 ? v1_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (en2 && v1_r) begin
      out_data_r.norm_left_x     <= res_a[0];
      out_data_r.norm_left_y     <= res_a[1];
      out_data_r.norm_right_x    <= res_a[2];
      out_data_r.norm_right_y    <= res_a[3];
      out_data_r.norm_left_trig  <= res_a[4];
      out_data_r.norm_right_trig <= res_a[5];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/gdr_recip.sv @@
// Restoring divider that forms ceil(2^32 / divisor), one quotient bit per cycle.
module gdr_recip (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [7:0]                  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [gdr_pkg::RECIP_W-1:0] quot
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [5:0]                    count_r, count_nxt;
  logic [7:0]                    div_r, div_nxt;
  logic [7:0]                    rem_r, rem_nxt;
  logic [gdr_pkg::RECIP_W-1:0]   work_r, work_nxt;
  logic [8:0]                    rem_sh;
  logic                          ge;

  assign rem_sh = {rem_r, work_r[gdr_pkg::RECIP_W-1]};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    work_nxt  = work_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          count_nxt = 6'(gdr_pkg::RECIP_W - 1);
          div_nxt   = divisor;
          rem_nxt   = 8'd0;
          // Dividend 2^32 + D - 1 turns the floor into a ceiling.
          work_nxt  = {1'b1, 24'd0, 8'(divisor - 8'd1)};
        end
      end
      ST_RUN: begin
        rem_nxt  = ge ? 8'(rem_sh - {1'b0, div_r}) : rem_sh[7:0];
        work_nxt = {work_r[gdr_pkg::RECIP_W-2:0], ge};
        if (count_r == 6'd0) begin
          state_nxt = ST_DONE;
        end else begin
          count_nxt = count_r - 6'd1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    count_r <= count_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    work_r  <= work_nxt;
  end

  assign busy = state_r != ST_IDLE;
  assign done = state_r == ST_DONE;
  assign quot = work_r;

endmodule

@@ rtl/core/gdr_lane.sv @@
// One deadzone lane: magnitude, deadzone removal, reciprocal multiply, saturation.
module gdr_lane (
  input  logic               clk,
  input  logic               en,
  input  gdr_pkg::lane_cfg_t lcfg,
  input  logic [7:0]         raw,
  output logic [15:0]        result
);

  logic                        neg;
  logic [7:0]                  mag;
  logic [7:0]                  m;
  logic                        below;

  logic [gdr_pkg::PROD_W-1:0]  prod_r;
  logic                        neg_r;
  logic                        zero_r;
  logic                        full_r;
  logic                        axis_r;

  logic [gdr_pkg::PROD_W-1:0]  q_wide;
  logic [gdr_pkg::PROD_W-1:0]  lim;
  logic [15:0]                 q16;
  logic [15:0]                 mag_res;

  // A raw -128 maps to magnitude 128, which still fits in eight bits.
  assign neg   = lcfg.axis & raw[7];
  assign mag   = neg ? 8'(~raw + 8'd1) : raw;
  assign below = mag < lcfg.dead;
  assign m     = 8'(mag - lcfg.dead);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= gdr_pkg::PROD_W'(m) * gdr_pkg::PROD_W'(lcfg.recip);
      neg_r  <= neg;
      zero_r <= below;
      full_r <= lcfg.full;
      axis_r <= lcfg.axis;
    end
  end

  // Axis scale is 2^15 / D and trigger scale is 2^16 / D against a 2^32 reciprocal.
  assign q_wide  = axis_r ? (prod_r >> 17) : (prod_r >> 16);
  assign lim     = axis_r ? gdr_pkg::PROD_W'(32767) : gdr_pkg::PROD_W'(65535);
  assign q16     = (q_wide > lim) ? lim[15:0] : q_wide[15:0];

  always_comb begin
    if (zero_r) begin
      mag_res = 16'd0;
    end else if (full_r) begin
      mag_res = lim[15:0];
    end else begin
      mag_res = q16;
    end
  end

  assign result = neg_r ? 16'(~mag_res + 16'd1) : mag_res;

endmodule

@@ rtl/core/gdr_checker.sv @@
// Port-level checker for the gamepad deadzone and rescale core, with its bind.
module gdr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input gdr_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input gdr_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               cfg_index,
  input logic [7:0]         cfg_wdata
);

  logic unused_ok;
  assign unused_ok = ^{in_data, cfg_index, cfg_wdata};

  // The result register comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An accepted request passes the lane and output registers or is queued behind one.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("accepted request produced no result");

  // A config write starts a reciprocal update, which holds off requests.
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall && !cfg_ready)
    else $error("requests accepted during reciprocal update");

endmodule

bind gamepad_deadzone_rescale_core gdr_checker u_gdr_checker (.*);

@@ tb/gamepad_deadzone_rescale_core_test.sv @@
// Self-checking testbench for the gamepad deadzone and rescale core.
module gamepad_deadzone_rescale_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef gdr_pkg::in_item_t  in_item_t;
  typedef gdr_pkg::out_item_t out_item_t;

  localparam int Q15_LIMIT   = 32767;
  localparam int Q16_LIMIT   = 65535;
  localparam int LATENCY     = 4;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 115;

  typedef struct {
    bit         set_cfg;
    logic [7:0] axis_w;
    logic [7:0] trig_w;
    in_item_t   sample;
    bit         typed;
    out_item_t  want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [7:0] cfg_wdata;

  // Mirror of the deadzone registers as the block should hold them.
  logic [6:0] axis_dead;
  logic [7:0] trig_dead;

  out_item_t pending_norm[$];
  dir_row_t  dir_rows[$];
  int        errors;
  int        idle_rate;
  int        stall_left;

  string lane_name[gdr_pkg::NUM_LANES] = '{"norm_left_x", "norm_left_y", "norm_right_x",
                                           "norm_right_y", "norm_left_trig",
                                           "norm_right_trig"};

  gamepad_deadzone_rescale_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [15:0] axis_norm(logic signed [7:0] v, int d);
    int mag;
    int q;
    mag = (v < 0) ? -int'(v) : int'(v);
    if (mag < d) return 16'd0;
    if (d >= int'(gdr_pkg::AXIS_FULL)) begin
      q = Q15_LIMIT;
    end else begin
      q = ((mag - d) * 32768) / (int'(gdr_pkg::AXIS_FULL) - d);
      if (q > Q15_LIMIT) q = Q15_LIMIT;
    end
    return (v < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic logic [15:0] trig_norm(logic [7:0] t, int d);
    int q;
    if (int'(t) < d) return 16'd0;
    if (d >= int'(gdr_pkg::TRIG_FULL)) return 16'(Q16_LIMIT);
    q = ((int'(t) - d) * 65536) / (int'(gdr_pkg::TRIG_FULL) - d);
    if (q > Q16_LIMIT) q = Q16_LIMIT;
    return 16'(q);
  endfunction

  function automatic out_item_t rescale_sample(in_item_t s);
    out_item_t r;
    r.norm_left_x     = axis_norm(s.left_x, int'(axis_dead));
    r.norm_left_y     = axis_norm(s.left_y, int'(axis_dead));
    r.norm_right_x    = axis_norm(s.right_x, int'(axis_dead));
    r.norm_right_y    = axis_norm(s.right_y, int'(axis_dead));
    r.norm_left_trig  = trig_norm(s.left_trig, int'(trig_dead));
    r.norm_right_trig = trig_norm(s.right_trig, int'(trig_dead));
    return r;
  endfunction

  // Most axis values are uniform; the rest sit on the deadzone edge, at full scale or at zero.
  function automatic logic [7:0] rand_axis();
    int m;
    case ($urandom_range(0, 5))
      3: begin
        m = int'(axis_dead) + int'($urandom_range(0, 4)) - 2;
        if (m < 0) m = 0;
        if (m > 128) m = 128;
        if ($urandom_range(0, 1) == 1) m = -m;
        return 8'(m);
      end
      4: begin
        case ($urandom_range(0, 3))
          0: return 8'h7F;
          1: return 8'h80;
          2: return 8'h81;
          default: return 8'h00;
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_trig();
    int t;
    case ($urandom_range(0, 5))
      3: begin
        t = int'(trig_dead) + int'($urandom_range(0, 4)) - 2;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return 8'(t);
      end
      4: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Results leave in order, so each one matches the oldest pending request.
  always @(posedge clk) begin
    logic [15:0] got;
    logic [15:0] exp_lane;
    out_item_t   want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_norm.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = pending_norm.pop_front();
        for (int i = 0; i < gdr_pkg::NUM_LANES; i++) begin
          got      = out_data[16*(gdr_pkg::NUM_LANES-1-i) +: 16];
          exp_lane = want[16*(gdr_pkg::NUM_LANES-1-i) +: 16];
          if (got !== exp_lane) begin
            $display("%0t: %s expected %h actual %h", $time, lane_name[i], exp_lane, got);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
      end else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
        stall_left = $urandom_range(1, 16);
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_sample(in_item_t s, bit typed, out_item_t want);
    int gap;
    @(negedge clk);
    if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    pending_norm.push_back(typed ? want : rescale_sample(s));
  endtask

  // Stop sending and let every pending result drain out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_norm.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == gdr_pkg::REG_AXIS_DEAD) axis_dead = value[6:0];
    else trig_dead = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_deadzones(logic [7:0] axis_w, logic [7:0] trig_w);
    drain_results();
    write_reg(gdr_pkg::REG_AXIS_DEAD, axis_w);
    write_reg(gdr_pkg::REG_TRIG_DEAD, trig_w);
  endtask

  initial begin
    out_item_t none;
    in_item_t  s;
    logic [7:0] axis_w;
    logic [7:0] trig_w;

    none       = '0;
    errors     = 0;
    idle_rate  = 0;
    axis_dead  = '0;
    trig_dead  = '0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = gdr_pkg::REG_AXIS_DEAD;
    cfg_wdata  = '0;

    // Field order: left_x, left_y, right_x, right_y, left_trig, right_trig.
    // Reset deadzones are zero: full scale saturates, -128 clamps to -32767.
    dir_rows.push_back('{0, 8'h00, 8'h00, in_item_t'(48'h0), 1, out_item_t'(96'h0)});
    dir_rows.push_back('{0, 8'h00, 8'h00, in_item_t'({8'h7F, 8'h80, 8'h81, 8'h01, 8'hFF, 8'h00}),
                         1, out_item_t'({16'h7FFF, 16'h8001, 16'h8001, 16'h0102, 16'hFFFF,
                                         16'h0000})});
    dir_rows.push_back('{0, 8'h00, 8'h00, in_item_t'({8'hFF, 8'h40, 8'hC0, 8'h00, 8'h01, 8'h80}),
                         0, none});
    dir_rows.push_back('{0, 8'h00, 8'h00, in_item_t'({8'h02, 8'hFE, 8'h55, 8'hAA, 8'hFE, 8'h7F}),
                         0, none});
    // Register maximums: only the very ends of each range get through, at full scale.
    dir_rows.push_back('{1, 8'h7F, 8'hFF, in_item_t'({8'h7E, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF}),
                         1, out_item_t'({16'h0000, 16'h7FFF, 16'h8001, 16'h8001, 16'h0000,
                                         16'hFFFF})});
    dir_rows.push_back('{0, 8'h00, 8'h00, in_item_t'({8'h00, 8'h82, 8'h01, 8'hFF, 8'h00, 8'h80}),
                         1, none});
    // Largest in-range deadzones: a divisor of one, so a single step saturates.
    dir_rows.push_back('{1, 8'h7E, 8'hFE, in_item_t'({8'h7D, 8'h7E, 8'h7F, 8'h80, 8'hFD, 8'hFE}),
                         1, out_item_t'({16'h0000, 16'h0000, 16'h7FFF, 16'h8001, 16'h0000,
                                         16'h0000})});
    dir_rows.push_back('{0, 8'h00, 8'h00, in_item_t'({8'h83, 8'h82, 8'h81, 8'h00, 8'hFF, 8'hFF}),
                         1, out_item_t'({16'h0000, 16'h0000, 16'h8001, 16'h0000, 16'hFFFF,
                                         16'hFFFF})});
    // The top bit of an axis write is dropped by the seven-bit register.
    dir_rows.push_back('{1, 8'hC0, 8'h80, in_item_t'({8'h3F, 8'h40, 8'h41, 8'hBF, 8'h7F, 8'h81}),
                         0, none});
    dir_rows.push_back('{0, 8'h00, 8'h00, in_item_t'({8'hC0, 8'hC1, 8'h7F, 8'h80, 8'h80, 8'hFF}),
                         0, none});
    dir_rows.push_back('{1, 8'h01, 8'h01, in_item_t'({8'h00, 8'h01, 8'hFF, 8'h02, 8'h00, 8'h01}),
                         0, none});
    dir_rows.push_back('{1, 8'h80, 8'h00, in_item_t'({8'h01, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE}),
                         0, none});
    dir_rows.push_back('{0, 8'h00, 8'h00, in_item_t'({8'hAA, 8'h55, 8'h33, 8'hCC, 8'hAA, 8'h55}),
                         0, none});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) set_deadzones(dir_rows[i].axis_w, dir_rows[i].trig_w);
      send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin axis_w = 8'h00; trig_w = 8'h00; end
        1: begin axis_w = 8'h7E; trig_w = 8'hFE; end
        2: begin axis_w = 8'h7F; trig_w = 8'hFF; end
        3: begin axis_w = 8'hFF; trig_w = 8'h00; end
        default: begin axis_w = 8'($urandom); trig_w = 8'($urandom); end
      endcase
      idle_rate = 0;
      set_deadzones(axis_w, trig_w);
      if (p != NUM_PHASES - 1) begin
        case ($urandom_range(0, 2))
          0: idle_rate = 0;
          1: idle_rate = 15;
          default: idle_rate = 40;
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the sender back once until the block has emptied.
        if (p == 4 && n == PHASE_ITEMS / 2) drain_results();
        s.left_x     = rand_axis();
        s.left_y     = rand_axis();
        s.right_x    = rand_axis();
        s.right_y    = rand_axis();
        s.left_trig  = rand_trig();
        s.right_trig = rand_trig();
        send_sample(s, 0, none);
      end
    end

    idle_rate = 0;
    drain_results();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
